// ===== sv/edcs_pkg.sv =====
// ----------------------------------------------------------------------------
// edcs_pkg
// Types, codes and fixed-point helpers shared by the disc collision step.
// ----------------------------------------------------------------------------
package edcs_pkg;

    // action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // reply codes
    localparam logic [1:0] REPLY_LOAD = 2'd0;
    localparam logic [1:0] REPLY_TICK = 2'd1;
    localparam logic [1:0] REPLY_READ = 2'd2;

    // divider and square root widths
    localparam int NUM_W  = 50;
    localparam int DEN_W  = 23;
    localparam int QUO_W  = 27;
    localparam int RAD_W  = 50;
    localparam int ROOT_W = 25;

    // quotient bits for the normal and for the velocity exchange
    localparam logic [5:0] QB_NORM = 6'd23;
    localparam logic [5:0] QB_VEL  = 6'd27;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [21:0]        rad;
        logic [21:0]        mass;
    } t_disc;

    // divide by 2^22, rounding toward zero
    function automatic logic signed [35:0] f_qtr(input logic signed [57:0] x);
        logic signed [57:0] t;
        t = x + (x[57] ? 58'sd4194303 : 58'sd0);
        return 36'(t >>> 22);
    endfunction

    function automatic logic signed [23:0] f_sat24(input logic signed [35:0] v);
        logic signed [23:0] r;
        if (v > 36'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -36'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/edcs_div.sv =====
// ----------------------------------------------------------------------------
// edcs_div
// Restoring unsigned divider, one quotient bit per cycle. The caller gives
// the number of quotient bits; the numerator shifted right by that count
// must be below the divisor.
// ----------------------------------------------------------------------------
module edcs_div import edcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [5:0]       i_qbits,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   r_rem;
    logic [5:0]       r_k;
    logic [QUO_W-1:0] r_q;
    logic             r_busy;
    logic             r_done;

    logic [5:0]       c_k;
    logic [DEN_W:0]   c_t;
    logic             c_ge;

    always_comb begin
        c_k  = r_k - 6'd1;
        c_t  = {r_rem[DEN_W-1:0], r_num[c_k]};
        c_ge = c_t >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= (DEN_W + 1)'(i_num >> i_qbits);
                r_k    <= i_qbits;
                r_q    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= c_ge ? (c_t - {1'b0, r_den}) : c_t;
                r_q   <= {r_q[QUO_W-2:0], c_ge};
                r_k   <= c_k;
                if (c_k == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== sv/edcs_sqrt.sv =====
// ----------------------------------------------------------------------------
// edcs_sqrt
// Integer square root, floor, one root bit per cycle.
// ----------------------------------------------------------------------------
module edcs_sqrt import edcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_k;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+3:0] c_t;
    logic [ROOT_W+3:0] c_trial;
    logic              c_ge;

    always_comb begin
        c_t     = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
        c_trial = {2'b00, r_root, 2'b01};
        c_ge    = c_t >= c_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_k    <= 5'(ROOT_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= c_ge ? (ROOT_W + 2)'(c_t - c_trial) : (ROOT_W + 2)'(c_t);
                r_root <= {r_root[ROOT_W-2:0], c_ge};
                r_rad  <= r_rad << 2;
                r_k    <= r_k - 5'd1;
                if (r_k == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== sv/elastic_disc_collision_step.sv =====
// ----------------------------------------------------------------------------
// elastic_disc_collision_step
// Disc store with load, read and one-tick elastic collision update.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready      | action, index, disc fields
//   out     | output    | o_out_valid / i_out_ready    | reply kind, disc read data
//
// After reset a clearing pass writes zero to all DISC_COUNT entries, one per
// cycle, before the first item is taken. A tick takes every disc and every
// later pair in turn: each pair goes through the serial square root, and a
// pair that collides also through the shared divider (one bit per cycle).
// One item is in work at a time; a held result stalls further input.
// ----------------------------------------------------------------------------
module elastic_disc_collision_step import edcs_pkg::*; #(
    parameter int DISC_COUNT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [5:0]         i_disc_index,
    input  logic signed [23:0] i_in_pos_x,
    input  logic signed [23:0] i_in_pos_y,
    input  logic signed [23:0] i_in_vel_x,
    input  logic signed [23:0] i_in_vel_y,
    input  logic [21:0]        i_in_radius,
    input  logic [21:0]        i_in_mass,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_reply_kind,
    output logic signed [23:0] o_out_pos_x,
    output logic signed [23:0] o_out_pos_y,
    output logic signed [23:0] o_out_vel_x,
    output logic signed [23:0] o_out_vel_y
);

    localparam int AW = (DISC_COUNT > 1) ? $clog2(DISC_COUNT) : 1;
    localparam logic [AW-1:0] LAST = AW'(DISC_COUNT - 1);

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_READ, S_A_RD, S_A_LD, S_B_RD, S_B_LD,
        S_DX2, S_DY2, S_D2, S_SQ_GO, S_SQ_WAIT, S_CHK, S_NX_WAIT, S_NY_WAIT,
        S_OX, S_OY, S_V0A1, S_V0A2, S_V0B1, S_V0B2, S_V0B3,
        S_MA, S_MB, S_DVA_GO, S_DVA_WAIT, S_DVB_WAIT,
        S_VA1, S_VA2, S_VB1, S_VB2, S_VB3, S_B_WB, S_WALL
    } t_state;

    t_state r_state;

    // disc store
    t_disc   mem [DISC_COUNT];
    t_disc   r_rdata;
    logic    c_we;
    logic [AW-1:0] c_waddr;
    logic [AW-1:0] c_raddr;
    t_disc   c_wdata;

    // sequencer
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic          r_rd_ok;

    // working discs
    logic signed [23:0] r_ax, r_ay, r_avx, r_avy;
    logic [21:0]        r_ar, r_am;
    logic signed [23:0] r_bx, r_by, r_bvx, r_bvy;
    logic [21:0]        r_br, r_bm;

    // pair arithmetic
    logic signed [24:0]  r_dx, r_dy;
    logic [RAD_W-1:0]    r_d2;
    logic [ROOT_W-1:0]   r_dv;
    logic signed [23:0]  r_nx, r_ny;
    logic [21:0]         r_corr;
    logic signed [55:0]  r_acc;
    logic signed [25:0]  r_v0a, r_v0b;
    logic signed [55:0]  r_na, r_nb;
    logic signed [27:0]  r_dva, r_dvb;
    logic signed [55:0]  r_prod;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic signed [23:0] r_opx, r_opy, r_ovx, r_ovy;

    // shared multiplier
    logic signed [27:0] c_ma, c_mb;
    logic signed [55:0] c_prod;

    // units
    logic             c_sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic             c_div_start, div_done;
    logic [NUM_W-1:0] c_div_num;
    logic [DEN_W-1:0] c_div_den;
    logic [5:0]       c_div_qb;
    logic [QUO_W-1:0] div_quo;

    // misc comb
    logic             c_acc_in;
    logic             c_idx_ok;
    logic [AW-1:0]    c_idx;
    logic [22:0]      c_rsum;
    logic [22:0]      c_msum;
    logic             c_skip;
    logic [24:0]      c_adx, c_ady;
    logic [55:0]      c_ana, c_anb;
    logic signed [26:0] c_dvd;
    logic signed [35:0] c_q;
    logic signed [24:0] c_lo, c_hi, c_px, c_py;
    logic signed [23:0] c_wx, c_wy, c_wvx, c_wvy;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign c_acc_in   = i_in_valid && o_in_ready;
    assign c_idx      = AW'(i_disc_index);
    assign c_idx_ok   = 32'(i_disc_index) < DISC_COUNT;

    always_comb begin
        c_rsum = {1'b0, r_ar} + {1'b0, r_br};
        c_msum = {1'b0, r_am} + {1'b0, r_bm};
        c_skip = (r_dv == '0) || (r_dv > ROOT_W'(c_rsum)) || (c_msum == '0);
        c_adx  = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
        c_ady  = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);
        c_ana  = r_na[55] ? 56'(-r_na) : 56'(r_na);
        c_anb  = r_nb[55] ? 56'(-r_nb) : 56'(r_nb);
        c_dvd  = 27'(r_v0b) - 27'(r_v0a);
        c_q    = f_qtr(58'(r_prod));
    end

    // operand select for the one multiplier
    always_comb begin
        c_ma = '0;
        c_mb = '0;
        case (r_state)
            S_DX2: begin
                c_ma = 28'(r_dx);
                c_mb = 28'(r_dx);
            end
            S_DY2: begin
                c_ma = 28'(r_dy);
                c_mb = 28'(r_dy);
            end
            S_OX: begin
                c_ma = 28'(r_nx);
                c_mb = 28'($signed({1'b0, r_corr}));
            end
            S_OY: begin
                c_ma = 28'(r_ny);
                c_mb = 28'($signed({1'b0, r_corr}));
            end
            S_V0A1: begin
                c_ma = 28'(r_avx);
                c_mb = 28'(r_nx);
            end
            S_V0A2: begin
                c_ma = 28'(r_avy);
                c_mb = 28'(r_ny);
            end
            S_V0B1: begin
                c_ma = 28'(r_bvx);
                c_mb = 28'(r_nx);
            end
            S_V0B2: begin
                c_ma = 28'(r_bvy);
                c_mb = 28'(r_ny);
            end
            S_MA: begin
                c_ma = 28'($signed({1'b0, r_bm, 1'b0}));
                c_mb = 28'(c_dvd);
            end
            S_MB: begin
                c_ma = 28'($signed({1'b0, r_am, 1'b0}));
                c_mb = 28'(-c_dvd);
            end
            S_VA1: begin
                c_ma = 28'(r_nx);
                c_mb = r_dva;
            end
            S_VA2: begin
                c_ma = 28'(r_ny);
                c_mb = r_dva;
            end
            S_VB1: begin
                c_ma = 28'(r_nx);
                c_mb = r_dvb;
            end
            S_VB2: begin
                c_ma = 28'(r_ny);
                c_mb = r_dvb;
            end
            default: begin
                c_ma = '0;
                c_mb = '0;
            end
        endcase
        c_prod = c_ma * c_mb;
    end

    // unit starts
    always_comb begin
        c_sq_start  = (r_state == S_SQ_GO);
        c_div_start = 1'b0;
        c_div_num   = '0;
        c_div_den   = '0;
        c_div_qb    = QB_NORM;
        case (r_state)
            S_CHK: begin
                c_div_start = !c_skip;
                c_div_num   = NUM_W'({c_adx, 22'd0});
                c_div_den   = r_dv[DEN_W-1:0];
                c_div_qb    = QB_NORM;
            end
            S_NX_WAIT: begin
                c_div_start = div_done;
                c_div_num   = NUM_W'({c_ady, 22'd0});
                c_div_den   = r_dv[DEN_W-1:0];
                c_div_qb    = QB_NORM;
            end
            S_DVA_GO: begin
                c_div_start = 1'b1;
                c_div_num   = c_ana[NUM_W-1:0];
                c_div_den   = c_msum;
                c_div_qb    = QB_VEL;
            end
            S_DVA_WAIT: begin
                c_div_start = div_done;
                c_div_num   = c_anb[NUM_W-1:0];
                c_div_den   = c_msum;
                c_div_qb    = QB_VEL;
            end
            default: begin
                c_div_start = 1'b0;
            end
        endcase
    end

    // wall clamp of disc a
    always_comb begin
        c_lo  = $signed({3'b000, r_ar}) - 25'sd4194304;
        c_hi  = 25'sd4194304 - $signed({3'b000, r_ar});
        c_px  = 25'(r_ax);
        c_py  = 25'(r_ay);
        c_wx  = r_ax;
        c_wvx = r_avx;
        c_wy  = r_ay;
        c_wvy = r_avy;
        if (c_px < c_lo) begin
            c_wx  = c_lo[23:0];
            c_wvx = f_sat24(-36'(r_avx));
        end else if (c_px > c_hi) begin
            c_wx  = c_hi[23:0];
            c_wvx = f_sat24(-36'(r_avx));
        end
        if (c_py < c_lo) begin
            c_wy  = c_lo[23:0];
            c_wvy = f_sat24(-36'(r_avy));
        end else if (c_py > c_hi) begin
            c_wy  = c_hi[23:0];
            c_wvy = f_sat24(-36'(r_avy));
        end
    end

    // memory port control
    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_i;
        c_wdata = '0;
        c_raddr = r_i;
        case (r_state)
            S_CLEAR: begin
                c_we = 1'b1;
            end
            S_IDLE: begin
                c_raddr = c_idx;
                c_waddr = c_idx;
                c_we    = c_acc_in && (i_action == ACT_LOAD) && c_idx_ok;
                c_wdata = '{px: i_in_pos_x, py: i_in_pos_y, vx: i_in_vel_x,
                            vy: i_in_vel_y, rad: i_in_radius, mass: i_in_mass};
            end
            S_B_RD: begin
                c_raddr = r_j;
            end
            S_B_WB: begin
                c_we    = 1'b1;
                c_waddr = r_j;
                c_wdata = '{px: r_bx, py: r_by, vx: r_bvx, vy: r_bvy,
                            rad: r_br, mass: r_bm};
            end
            S_WALL: begin
                c_we    = 1'b1;
                c_wdata = '{px: c_wx, py: c_wy, vx: c_wvx, vy: c_wvy,
                            rad: r_ar, mass: r_am};
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            mem[c_waddr] <= c_wdata;
        end
        r_rdata <= mem[c_raddr];
    end

    edcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_sq_start),
        .i_rad   (r_d2),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    edcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_div_start),
        .i_num   (c_div_num),
        .i_den   (c_div_den),
        .i_qbits (c_div_qb),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= c_prod;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_i == LAST) begin
                        r_i     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (c_acc_in) begin
                        r_opx <= '0;
                        r_opy <= '0;
                        r_ovx <= '0;
                        r_ovy <= '0;
                        case (i_action)
                            ACT_LOAD: begin
                                r_kind      <= REPLY_LOAD;
                                r_out_valid <= 1'b1;
                            end
                            ACT_TICK: begin
                                r_i     <= '0;
                                r_state <= S_A_RD;
                            end
                            ACT_READ: begin
                                r_rd_ok <= c_idx_ok;
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_kind      <= REPLY_READ;
                    r_out_valid <= 1'b1;
                    if (r_rd_ok) begin
                        r_opx <= r_rdata.px;
                        r_opy <= r_rdata.py;
                        r_ovx <= r_rdata.vx;
                        r_ovy <= r_rdata.vy;
                    end
                    r_state <= S_IDLE;
                end
                S_A_RD: begin
                    r_state <= S_A_LD;
                end
                S_A_LD: begin
                    r_ax  <= f_sat24(36'(r_rdata.px) + 36'(r_rdata.vx));
                    r_ay  <= f_sat24(36'(r_rdata.py) + 36'(r_rdata.vy));
                    r_avx <= r_rdata.vx;
                    r_avy <= r_rdata.vy;
                    r_ar  <= r_rdata.rad;
                    r_am  <= r_rdata.mass;
                    if (r_i == LAST) begin
                        r_state <= S_WALL;
                    end else begin
                        r_j     <= r_i + 1'b1;
                        r_state <= S_B_RD;
                    end
                end
                S_B_RD: begin
                    r_state <= S_B_LD;
                end
                S_B_LD: begin
                    r_bx    <= r_rdata.px;
                    r_by    <= r_rdata.py;
                    r_bvx   <= r_rdata.vx;
                    r_bvy   <= r_rdata.vy;
                    r_br    <= r_rdata.rad;
                    r_bm    <= r_rdata.mass;
                    r_dx    <= 25'(r_rdata.px) - 25'(r_ax);
                    r_dy    <= 25'(r_rdata.py) - 25'(r_ay);
                    r_state <= S_DX2;
                end
                S_DX2: begin
                    r_state <= S_DY2;
                end
                S_DY2: begin
                    r_d2    <= r_prod[RAD_W-1:0];
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_d2    <= r_d2 + r_prod[RAD_W-1:0];
                    r_state <= S_SQ_GO;
                end
                S_SQ_GO: begin
                    r_state <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (sq_done) begin
                        r_dv    <= sq_root;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // skipped pair: write disc b back unchanged
                    r_corr  <= 22'((c_rsum - r_dv[22:0]) >> 1);
                    r_state <= c_skip ? S_B_WB : S_NX_WAIT;
                end
                S_NX_WAIT: begin
                    if (div_done) begin
                        r_nx    <= r_dx[24] ? -24'(div_quo) : 24'(div_quo);
                        r_state <= S_NY_WAIT;
                    end
                end
                S_NY_WAIT: begin
                    if (div_done) begin
                        r_ny    <= r_dy[24] ? -24'(div_quo) : 24'(div_quo);
                        r_state <= S_OX;
                    end
                end
                S_OX: begin
                    r_state <= S_OY;
                end
                S_OY: begin
                    r_ax    <= f_sat24(36'(r_ax) - c_q);
                    r_bx    <= f_sat24(36'(r_bx) + c_q);
                    r_state <= S_V0A1;
                end
                S_V0A1: begin
                    r_ay    <= f_sat24(36'(r_ay) - c_q);
                    r_by    <= f_sat24(36'(r_by) + c_q);
                    r_state <= S_V0A2;
                end
                S_V0A2: begin
                    r_acc   <= r_prod;
                    r_state <= S_V0B1;
                end
                S_V0B1: begin
                    r_v0a   <= 26'(f_qtr(58'(r_acc) + 58'(r_prod)));
                    r_state <= S_V0B2;
                end
                S_V0B2: begin
                    r_acc   <= r_prod;
                    r_state <= S_V0B3;
                end
                S_V0B3: begin
                    r_v0b   <= 26'(f_qtr(58'(r_acc) + 58'(r_prod)));
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_na    <= r_prod;
                    r_state <= S_DVA_GO;
                end
                S_DVA_GO: begin
                    r_nb    <= r_prod;
                    r_state <= S_DVA_WAIT;
                end
                S_DVA_WAIT: begin
                    if (div_done) begin
                        r_dva   <= r_na[55] ? -28'(div_quo) : 28'(div_quo);
                        r_state <= S_DVB_WAIT;
                    end
                end
                S_DVB_WAIT: begin
                    if (div_done) begin
                        r_dvb   <= r_nb[55] ? -28'(div_quo) : 28'(div_quo);
                        r_state <= S_VA1;
                    end
                end
                S_VA1: begin
                    r_state <= S_VA2;
                end
                S_VA2: begin
                    r_avx   <= f_sat24(36'(r_avx) + c_q);
                    r_state <= S_VB1;
                end
                S_VB1: begin
                    r_avy   <= f_sat24(36'(r_avy) + c_q);
                    r_state <= S_VB2;
                end
                S_VB2: begin
                    r_bvx   <= f_sat24(36'(r_bvx) + c_q);
                    r_state <= S_VB3;
                end
                S_VB3: begin
                    r_bvy   <= f_sat24(36'(r_bvy) + c_q);
                    r_state <= S_B_WB;
                end
                S_B_WB: begin
                    if (r_j == LAST) begin
                        r_state <= S_WALL;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_B_RD;
                    end
                end
                S_WALL: begin
                    if (r_i == LAST) begin
                        r_i         <= '0;
                        r_kind      <= REPLY_TICK;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_A_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reply_kind = r_kind;
    assign o_out_pos_x  = r_opx;
    assign o_out_pos_y  = r_opy;
    assign o_out_vel_x  = r_ovx;
    assign o_out_vel_y  = r_ovy;

endmodule
